FILE: hw/rtl/ssad_pkg.sv
// Package for the shifted 3x3 SAD accumulator: shared types and constants.
// No dependencies.
package ssad_pkg;

  localparam int unsigned NumSums = 9;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MASK_ENABLE  = 2'd2,
    REG_MASK_INDEX   = 2'd3
  } reg_idx_e;

  // One accepted pixel, classified by the front part.
  typedef struct packed {
    logic [7:0] cur;
    logic [7:0] bg;
    logic       hit;
    logic       slot;
    logic       accum_en;
    logic       end_frame;
  } pix_cmd_t;

endpackage

FILE: hw/rtl/ssad_if.sv
// Valid/ready channel interfaces for the shifted 3x3 SAD accumulator.
// Depends on nothing.
interface ssad_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] current_pixel;
  logic [7:0] background_pixel;
  logic [7:0] mask_pixel;
  modport source (output valid, current_pixel, background_pixel, mask_pixel, input ready);
  modport sink   (input valid, current_pixel, background_pixel, mask_pixel, output ready);
endinterface

interface ssad_sum_if;
  logic        valid;
  logic        ready;
  logic [3:0]  sum_index;
  logic [31:0] sum_value;
  logic        last_sum;
  modport source (output valid, sum_index, sum_value, last_sum, input ready);
  modport sink   (input valid, sum_index, sum_value, last_sum, output ready);
endinterface

interface ssad_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/shifted_sad_3x3_accumulator.sv
// Top level of the shifted 3x3 SAD accumulator.
// Depends on ssad_pkg, the channel interfaces, ssad_front, ssad_queue, ssad_back.
//
// Usage: pixels (current, background, mask) enter on pix in raster order, one
// per cycle when the block is ready. For each interior pixel the absolute
// differences against its nine neighbor backgrounds are added into nine sums.
// After the last pixel of a frame, nine results leave on sum, index 0 to 8,
// last_sum set on the ninth; the sums then restart from zero.
// Throughput: one pixel per cycle unless a frame end must wait for results to
// drain; the single-port line stores are read and written at the same column
// for each pixel.
// The front counts columns and rows; a two-entry queue feeds the back, which
// holds the line stores, the 3x2 window and the sums.
// While the results of one frame drain, the next frame's pixels keep being
// taken; only its final pixel waits until all nine results have left.
// A stalled receiver holds the current result steady.
// Reset clears counters, window and sums; line stores need no clearing.
// Configuration is written on cfg (index 0 width, 1 height, 2 mask enable,
// 3 mask index); the user must do so while the block is idle; it is not enforced.
module shifted_sad_3x3_accumulator #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input logic        clk_i,
  input logic        rst_ni,
  ssad_pix_if.sink   pix,
  ssad_sum_if.source sum,
  ssad_cfg_if.sink   cfg
);
  import ssad_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned QW = $bits(pix_cmd_t) + CW;

  logic [12:0] width_q, height_q;
  logic        mask_en_q;
  logic [7:0]  mask_idx_q;

  // Configuration registers.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= 13'd640;
      height_q   <= 13'd480;
      mask_en_q  <= 1'b0;
      mask_idx_q <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FRAME_WIDTH:  width_q    <= cfg.data;
        REG_FRAME_HEIGHT: height_q   <= cfg.data;
        REG_MASK_ENABLE:  mask_en_q  <= cfg.data[0];
        REG_MASK_INDEX:   mask_idx_q <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  logic          f_valid, f_ready, b_valid, b_ready;
  pix_cmd_t      f_cmd, b_cmd;
  logic [CW-1:0] f_col, b_col;

  ssad_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(pix.valid), .in_ready_o(pix.ready),
    .cur_i(pix.current_pixel), .bg_i(pix.background_pixel), .msk_i(pix.mask_pixel),
    .width_i(width_q), .height_i(height_q),
    .mask_en_i(mask_en_q), .mask_idx_i(mask_idx_q),
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready),
    .cmd_o(f_cmd), .cmd_col_o(f_col)
  );

  ssad_queue #(.DW(QW)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i({f_cmd, f_col}),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_data_o({b_cmd, b_col})
  );

  ssad_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd), .col_i(b_col),
    .out_valid_o(sum.valid), .out_ready_i(sum.ready),
    .sum_index_o(sum.sum_index), .sum_value_o(sum.sum_value),
    .last_sum_o(sum.last_sum)
  );
endmodule

FILE: hw/rtl/ssad_front.sv
// Front part: position counters, mask classification and frame end detection.
// Depends on ssad_pkg.
module ssad_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         cur_i,
  input  logic [7:0]         bg_i,
  input  logic [7:0]         msk_i,
  input  logic [12:0]        width_i,
  input  logic [12:0]        height_i,
  input  logic               mask_en_i,
  input  logic [7:0]         mask_idx_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output ssad_pkg::pix_cmd_t cmd_o,
  output logic [$clog2(MAX_WIDTH)-1:0] cmd_col_o
);
  import ssad_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned SW = (CW > RW ? CW : RW) + 1;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [SW-1:0] w_c, h_c, x1, y1;
  logic          end_row, end_frame, fire;

  // Clamp the frame size into the supported range.
  always_comb begin
    if (13'(width_i) < 13'd3) w_c = SW'(3);
    else if (SW'(width_i) > SW'(MAX_WIDTH) || (13 > SW && |(width_i >> SW)))
      w_c = SW'(MAX_WIDTH);
    else w_c = SW'(width_i);
    if (height_i < 13'd3) h_c = SW'(3);
    else if (SW'(height_i) > SW'(MAX_HEIGHT) || (13 > SW && |(height_i >> SW)))
      h_c = SW'(MAX_HEIGHT);
    else h_c = SW'(height_i);
  end

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign fire        = in_valid_i && cmd_ready_i;
  assign x1          = SW'(col_q) + SW'(1);
  assign y1          = SW'(row_q) + SW'(1);
  assign end_row     = x1 >= w_c;
  assign end_frame   = end_row && (y1 >= h_c);

  // Classify the pixel for the back part.
  always_comb begin
    cmd_o.cur       = cur_i;
    cmd_o.bg        = bg_i;
    cmd_o.hit       = mask_en_i ? (msk_i == mask_idx_i) : 1'b1;
    cmd_o.slot      = row_q[0];
    cmd_o.accum_en  = (row_q >= RW'(2)) && (col_q >= CW'(2));
    cmd_o.end_frame = end_frame;
    cmd_col_o       = col_q;
  end

  // Next position.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (fire) begin
      if (end_frame) begin
        col_d = '0;
        row_d = '0;
      end else if (end_row) begin
        col_d = '0;
        row_d = RW'(y1);
      end else begin
        col_d = CW'(x1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end
endmodule

FILE: hw/rtl/ssad_queue.sv
// Two-entry queue between the front and back parts.
// Depends on ssad_pkg.
module ssad_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [DW-1:0] in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [DW-1:0] out_data_o
);
  import ssad_pkg::*;

  logic [DW-1:0] mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

FILE: hw/rtl/ssad_back.sv
// Back part: line stores, 3x2 background window, nine sums and result output.
// Depends on ssad_pkg.
module ssad_back #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  ssad_pkg::pix_cmd_t           cmd_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [3:0]                   sum_index_o,
  output logic [31:0]                  sum_value_o,
  output logic                         last_sum_o
);
  import ssad_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  // Line stores, written and read at the same column, read data registered.
  logic [7:0] bg0_mem [MAX_WIDTH];
  logic [7:0] bg1_mem [MAX_WIDTH];
  logic [8:0] cur_mem [MAX_WIDTH];

  // Stage 1 registers: the command and the line reads.
  logic       s1_v_q;
  pix_cmd_t   s1_q;
  logic [7:0] rd0_q, rd1_q;
  logic [8:0] rdc_q;

  logic [7:0]  win_q [3][2];
  logic [7:0]  hcur_q;
  logic        hhit_q;
  logic [31:0] sums_q [NumSums];
  logic [31:0] snap_q [NumSums];
  logic [3:0]  oidx_q;
  logic        busy_q;
  logic        s1_go, take;
  logic [7:0]  newc [3];

  // A frame end may not enter while the previous results still drain.
  assign take        = cmd_valid_i && cmd_ready_o;
  assign cmd_ready_o = !(busy_q && s1_v_q && s1_q.end_frame) &&
                       !(busy_q && cmd_i.end_frame);
  assign s1_go       = s1_v_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      rd0_q <= cmd_i.slot ? bg1_mem[col_i] : bg0_mem[col_i];
      rd1_q <= cmd_i.slot ? bg0_mem[col_i] : bg1_mem[col_i];
      rdc_q <= cur_mem[col_i];
      s1_q  <= cmd_i;
      if (cmd_i.slot) bg1_mem[col_i] <= cmd_i.bg;
      else bg0_mem[col_i] <= cmd_i.bg;
      cur_mem[col_i] <= {cmd_i.hit, cmd_i.cur};
    end
  end

  assign newc[0] = rd0_q;
  assign newc[1] = rd1_q;
  assign newc[2] = s1_q.bg;

  // Window, held center and accumulation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      hcur_q <= '0;
      hhit_q <= 1'b0;
      busy_q <= 1'b0;
      oidx_q <= '0;
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= '0;
        win_q[i][1] <= '0;
      end
      for (int k = 0; k < NumSums; k++) sums_q[k] <= '0;
    end else begin
      s1_v_q <= take;
      if (s1_go) begin
        hcur_q <= rdc_q[7:0];
        hhit_q <= rdc_q[8];
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= newc[i];
        end
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            logic [7:0] b, d;
            b = (j == 2) ? newc[i] : win_q[i][j];
            d = (hcur_q > b) ? hcur_q - b : b - hcur_q;
            if (s1_q.end_frame) sums_q[i*3+j] <= '0;
            else if (s1_q.accum_en && hhit_q) sums_q[i*3+j] <= sums_q[i*3+j] + 32'(d);
            // The snapshot is taken only at the frame end and holds while it drains.
            if (s1_q.end_frame) begin
              if (s1_q.accum_en && hhit_q) snap_q[i*3+j] <= sums_q[i*3+j] + 32'(d);
              else snap_q[i*3+j] <= sums_q[i*3+j];
            end
          end
        end
        if (s1_q.end_frame) begin
          busy_q <= 1'b1;
          oidx_q <= '0;
        end
      end
      if (busy_q && out_ready_i) begin
        if (oidx_q == 4'(NumSums - 1)) busy_q <= 1'b0;
        oidx_q <= oidx_q + 4'd1;
      end
    end
  end

  assign out_valid_o = busy_q;
  assign sum_index_o = oidx_q;
  assign sum_value_o = snap_q[oidx_q];
  assign last_sum_o  = oidx_q == 4'(NumSums - 1);
endmodule

FILE: hw/rtl/ssad_checker.sv
// Port-level checker for the shifted 3x3 SAD accumulator, bound to the top.
// Depends on the top level's ports only.
module ssad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        sum_valid,
  input logic        sum_ready,
  input logic [3:0]  sum_index,
  input logic [31:0] sum_value,
  input logic        last_sum
);
  // The last flag marks exactly the ninth result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid |-> (last_sum == (sum_index == 4'd8)))
    else $error("last flag out of place");

  // Result indexes advance by one within a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid && sum_ready && !last_sum |=> sum_valid && sum_index == $past(sum_index) + 4'd1)
    else $error("result sequence broken");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_valid && !sum_ready |=> sum_valid && $stable(sum_value))
    else $error("stalled result changed");
endmodule

bind shifted_sad_3x3_accumulator ssad_checker u_ssad_checker (
  .clk_i, .rst_ni,
  .sum_valid(sum.valid), .sum_ready(sum.ready), .sum_index(sum.sum_index),
  .sum_value(sum.sum_value), .last_sum(sum.last_sum)
);

FILE: dv/testbench.sv
// Self-checking testbench for the shifted 3x3 SAD accumulator.
// Depends on ssad_pkg, the channel interfaces in ssad_if.sv and the top level RTL.
module testbench;
  import ssad_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxW = 4096;
  localparam int unsigned MaxH = 4096;
  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ssad_pix_if pix ();
  ssad_sum_if sum ();
  ssad_cfg_if cfg ();

  shifted_sad_3x3_accumulator #(.MAX_WIDTH(MaxW), .MAX_HEIGHT(MaxH)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix   (pix),
    .sum   (sum),
    .cfg   (cfg)
  );

  always #6 clk_i = ~clk_i;

  typedef struct packed {
    logic [3:0]  idx;
    logic [31:0] value;
    logic        last;
  } sum_rec_t;

  // Shadow copy of the configuration and of the block's state.
  logic [12:0] width_reg, height_reg;
  logic        mask_en_reg;
  logic [7:0]  mask_idx_reg;
  logic [7:0]  bg_lines [2][MaxW];
  logic [7:0]  cur_line [MaxW];
  logic        hit_line [MaxW];
  logic [7:0]  bg_win [3][2];
  logic [7:0]  held_cur;
  logic        held_hit;
  logic [31:0] sad_acc [9];
  int unsigned col_cnt, row_cnt;

  sum_rec_t expected_sums[$];
  int errors = 0;
  int frames_done = 0;
  int pixels_sent = 0;
  int sums_seen = 0;
  int idle_cycles = 0;

  function automatic int unsigned clamp_dim(logic [12:0] v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic logic [31:0] absdiff(logic [7:0] a, logic [7:0] b);
    return (a > b) ? 32'(a - b) : 32'(b - a);
  endfunction

  // Predict the effect of one accepted pixel on the sums and the line stores.
  function automatic void predict_pixel(logic [7:0] cp, logic [7:0] bp, logic [7:0] mp);
    int unsigned w, h, x, y;
    logic        hit, slot, chit;
    logic [7:0]  col [3];
    logic [7:0]  c_cur;
    sum_rec_t    r;
    w = clamp_dim(width_reg, MaxW);
    h = clamp_dim(height_reg, MaxH);
    x = (col_cnt >= MaxW) ? MaxW - 1 : col_cnt;
    y = row_cnt;
    hit = mask_en_reg ? (mp == mask_idx_reg) : 1'b1;
    slot = y[0];
    c_cur = held_cur;
    chit = held_hit;
    col[0] = bg_lines[slot][x];
    col[1] = bg_lines[~slot][x];
    col[2] = bp;
    held_cur = cur_line[x];
    held_hit = hit_line[x];
    if (y >= 2 && x >= 2 && chit) begin
      for (int i = 0; i < 3; i++) begin
        sad_acc[i*3+0] += absdiff(c_cur, bg_win[i][0]);
        sad_acc[i*3+1] += absdiff(c_cur, bg_win[i][1]);
        sad_acc[i*3+2] += absdiff(c_cur, col[i]);
      end
    end
    bg_lines[slot][x] = bp;
    cur_line[x] = cp;
    hit_line[x] = hit;
    for (int i = 0; i < 3; i++) begin
      bg_win[i][0] = bg_win[i][1];
      bg_win[i][1] = col[i];
    end
    if (x + 1 >= w && y + 1 >= h) begin
      for (int j = 0; j < 9; j++) begin
        r.idx = 4'(j);
        r.value = sad_acc[j];
        r.last = (j == NumSums - 1);
        expected_sums.push_back(r);
        sad_acc[j] = '0;
      end
      col_cnt = 0;
      row_cnt = 0;
    end else if (x + 1 >= w) begin
      col_cnt = 0;
      row_cnt = y + 1;
    end else begin
      col_cnt = x + 1;
    end
  endfunction

  // Watchdog on cycles without any accepted request.
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (sum.valid && sum.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result checker: compares each accepted sum with the oldest expectation.
  always @(posedge clk_i) begin
    sum_rec_t e;
    if (rst_ni && sum.valid && sum.ready) begin
      sums_seen++;
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected sum idx=%0d value=%0d", $time, sum.sum_index, sum.sum_value);
        errors++;
      end else begin
        e = expected_sums.pop_front();
        if (sum.sum_index !== e.idx) begin
          $display("%0t: sum_index expected %0d actual %0d", $time, e.idx, sum.sum_index);
          errors++;
        end
        if (sum.sum_value !== e.value) begin
          $display("%0t: sum_value expected %0d actual %0d", $time, e.value, sum.sum_value);
          errors++;
        end
        if (sum.last_sum !== e.last) begin
          $display("%0t: last_sum expected %0b actual %0b", $time, e.last, sum.last_sum);
          errors++;
        end
        if (e.last) frames_done++;
      end
    end
  end

  // Receiver side: random stalls between results, with a stall-free window.
  bit no_stall = 0;
  initial begin
    int unsigned gap;
    sum.ready = 1'b0;
    wait (rst_ni);
    forever begin
      gap = no_stall ? 0 : $urandom_range(0, 11);
      repeat (gap) @(negedge clk_i);
      @(negedge clk_i);
      sum.ready <= 1'b1;
      do @(posedge clk_i); while (!sum.valid);
      if (!no_stall) begin
        @(negedge clk_i);
        sum.ready <= 1'b0;
      end
    end
  end

  bit send_burst = 0;

  // Sends one pixel request and updates the prediction on acceptance.
  task automatic send_pixel(logic [7:0] cp, logic [7:0] bp, logic [7:0] mp);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      @(negedge clk_i);
      pix.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    pix.valid <= 1'b1;
    pix.current_pixel <= cp;
    pix.background_pixel <= bp;
    pix.mask_pixel <= mp;
    do @(posedge clk_i); while (!pix.ready);
    predict_pixel(cp, bp, mp);
    pixels_sent++;
  endtask

  task automatic write_reg(reg_idx_e idx, logic [12:0] val);
    @(negedge clk_i);
    pix.valid <= 1'b0;
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      REG_FRAME_WIDTH:  width_reg = val;
      REG_FRAME_HEIGHT: height_reg = val;
      REG_MASK_ENABLE:  mask_en_reg = val[0];
      REG_MASK_INDEX:   mask_idx_reg = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  // Waits until every expected sum has come, then lets the pipeline settle.
  task automatic drain_sums();
    @(negedge clk_i);
    pix.valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic setup(int w, int h, bit men, logic [7:0] midx);
    drain_sums();
    write_reg(REG_FRAME_WIDTH, 13'(w));
    write_reg(REG_FRAME_HEIGHT, 13'(h));
    write_reg(REG_MASK_ENABLE, 13'(men));
    write_reg(REG_MASK_INDEX, 13'(midx));
  endtask

  // Smallest frame with field extremes: all zero vs all full scale.
  task automatic test_extremes();
    setup(3, 3, 0, 8'h00);
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, 8'h00, 8'h00);
    for (int i = 0; i < 9; i++) send_pixel(8'h00, 8'hFF, 8'hFF);
  endtask

  // Masked mode with the top mask index; four of the nine pixels hit.
  task automatic test_masked_small();
    setup(3, 3, 1, 8'hFF);
    for (int i = 0; i < 9; i++)
      send_pixel(8'($urandom), 8'($urandom), (i % 2) ? 8'hFF : 8'h7F);
  endtask

  // Random frames of random small sizes and mask settings.
  task automatic test_random_frames(int n_frames);
    int w, h;
    bit men;
    logic [7:0] midx;
    for (int f = 0; f < n_frames; f++) begin
      w = $urandom_range(3, 6);
      h = $urandom_range(3, 5);
      men = $urandom_range(0, 1);
      midx = 8'($urandom_range(0, 3));
      setup(w, h, men, midx);
      send_burst = ($urandom_range(0, 3) == 0);
      no_stall = send_burst;
      for (int i = 0; i < w * h; i++)
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom_range(0, 3)));
      send_burst = 0;
      no_stall = 0;
    end
  endtask

  // Back-to-back frames without idling, then a frame with 40-pixel rows.
  task automatic test_back_to_back();
    setup(0, 8191, 0, 8'h00);
    setup(3, 3, 0, 8'h00);
    send_burst = 1;
    no_stall = 1;
    for (int f = 0; f < 3; f++)
      for (int i = 0; i < 9; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    send_burst = 0;
    no_stall = 0;
    setup(40, 3, 0, 8'h00);
    for (int i = 0; i < 120; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    width_reg = 13'd640;
    height_reg = 13'd480;
    mask_en_reg = 1'b0;
    mask_idx_reg = 8'h00;
    for (int i = 0; i < MaxW; i++) begin
      bg_lines[0][i] = '0;
      bg_lines[1][i] = '0;
      cur_line[i] = '0;
      hit_line[i] = 1'b0;
    end
    for (int i = 0; i < 3; i++) bg_win[i] = '{8'h00, 8'h00};
    for (int j = 0; j < 9; j++) sad_acc[j] = '0;
    held_cur = '0;
    held_hit = 1'b0;
    col_cnt = 0;
    row_cnt = 0;
    pix.valid = 1'b0;
    pix.current_pixel = '0;
    pix.background_pixel = '0;
    pix.mask_pixel = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_FRAME_WIDTH;
    cfg.data = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_masked_small();
    test_back_to_back();
    test_random_frames(5);
    drain_sums();
    $display("Covered %0d pixels in %0d frames, %0d sums checked.",
             pixels_sent, frames_done, sums_seen);
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: shifted_sad_3x3_accumulator.f
hw/rtl/ssad_pkg.sv
hw/rtl/ssad_if.sv
hw/rtl/ssad_front.sv
hw/rtl/ssad_queue.sv
hw/rtl/ssad_back.sv
hw/rtl/shifted_sad_3x3_accumulator.sv
hw/rtl/ssad_checker.sv
dv/testbench.sv
